// File: rtl/iee_pkg.sv
// Shared constants, command codes, status types and tables of the infix evaluator.
package iee_pkg;

   localparam int NUM_STACK_DEPTH = 4;
   localparam int FRAC_BITS = 16;
   localparam int MAX_FRAC_DIGITS = 6;

   localparam int CNT_W = $clog2(NUM_STACK_DEPTH + 1);
   localparam int IDX_W = $clog2(NUM_STACK_DEPTH);
   localparam int INT_W = 32 - FRAC_BITS;
   localparam int FRAC_ACC_W = 20;
   localparam int DIG_W = 3;
   localparam int DIV_DW = 32 + FRAC_BITS;
   localparam int DIV_VW = 32;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_MALFORMED = 2'd3;

   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   localparam logic [3:0] CMD_NONE = 4'd0;
   localparam logic [3:0] CMD_CAPTURE = 4'd1;
   localparam logic [3:0] CMD_DIGIT = 4'd2;
   localparam logic [3:0] CMD_DOT = 4'd3;
   localparam logic [3:0] CMD_TOK_START = 4'd4;
   localparam logic [3:0] CMD_TOK_PUSH = 4'd5;
   localparam logic [3:0] CMD_POP = 4'd6;
   localparam logic [3:0] CMD_ADDSUB = 4'd7;
   localparam logic [3:0] CMD_MUL_PROD = 4'd8;
   localparam logic [3:0] CMD_MUL_FIN = 4'd9;
   localparam logic [3:0] CMD_DIV_ZERO = 4'd10;
   localparam logic [3:0] CMD_DIV_START = 4'd11;
   localparam logic [3:0] CMD_DIV_FIN = 4'd12;
   localparam logic [3:0] CMD_PUSH_OP = 4'd13;
   localparam logic [3:0] CMD_RESULT = 4'd14;

   typedef struct packed {
      logic [3:0] code;
   } iee_cmd_type;

   typedef struct packed {
      logic       is_digit;
      logic       is_dot;
      logic       is_op;
      logic       last;
      logic       active;
      logic       op_nonzero;
      logic       reduce_ok;
      logic       pop_short;
      logic [1:0] pop_op;
      logic       divisor_zero;
      logic       div_done;
   } iee_status_type;

   function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [DIG_W-1:0] n);
      logic [FRAC_ACC_W-1:0] p;
      case (n)
         3'd0: p = 20'd1;
         3'd1: p = 20'd10;
         3'd2: p = 20'd100;
         3'd3: p = 20'd1000;
         3'd4: p = 20'd10000;
         3'd5: p = 20'd100000;
         default: p = 20'd1000000;
      endcase
      return p;
   endfunction

endpackage

// File: rtl/iee_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
module iee_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [iee_pkg::DIV_DW-1:0] dividend,
   input  logic [iee_pkg::DIV_VW-1:0] divisor,
   output logic                      done,
   output logic [iee_pkg::DIV_DW-1:0] quotient
);
   import iee_pkg::*;

   localparam int CW = $clog2(DIV_DW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DIV_VW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] quo_ff, quo_in;
   logic [DIV_VW-1:0] dsr_ff, dsr_in;
   logic [DIV_VW:0]   trial;
   logic              fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DIV_DW-1]};
      fits = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in = CW'(DIV_DW);
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_VW'(trial - {1'b0, dsr_ff}) : DIV_VW'(trial);
         quo_in = {quo_ff[DIV_DW-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/iee_datapath.sv
// Datapath of the infix evaluator: number builder, stacks, arithmetic and result register.
module iee_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  iee_pkg::iee_cmd_type    cmd,
   output iee_pkg::iee_status_type status,
   input  logic [7:0]             req_ch,
   input  logic                   req_last,
   output logic signed [31:0]     rsp_value,
   output logic [1:0]             rsp_status
);
   import iee_pkg::*;

   localparam logic [INT_W-1:0] INT_CAP = INT_W'(1) << (31 - FRAC_BITS);
   localparam logic [32:0] Q_MAX33 = 33'h0_7FFF_FFFF;

   logic [7:0]            ch_ff;
   logic                  last_ff;
   logic [INT_W-1:0]      int_ff, int_in;
   logic [FRAC_ACC_W-1:0] frac_ff, frac_in;
   logic [DIG_W-1:0]      dig_ff, dig_in;
   logic                  fl_active_ff, fl_active_in;
   logic                  fl_dot_ff, fl_dot_in;
   logic                  fl_end_ff, fl_end_in;
   logic [1:0]            err_ff, err_in;
   logic [CNT_W-1:0]      num_count_ff, num_count_in;
   logic [1:0]            op_count_ff, op_count_in;
   logic [1:0]            op_stack_ff [2];
   logic [1:0]            op_ff;
   logic                  short_ff;
   logic signed [31:0]    a_ff, b_ff;
   logic signed [63:0]    prod_ff;
   logic                  neg_ff;
   logic signed [31:0]    num_mem [NUM_STACK_DEPTH];
   logic signed [31:0]    value_ff;
   logic [1:0]            status_ff;

   logic [CNT_W-1:0]      cnt_m1, cnt_m2;
   logic [3:0]            digit;
   logic [INT_W+3:0]      int_next;
   logic [FRAC_ACC_W+3:0] frac_next;
   logic                  is_op;
   logic [1:0]            new_op;
   logic [1:0]            top_op;
   logic                  div_start, div_done;
   logic [DIV_DW-1:0]     div_dividend, div_quotient;
   logic [DIV_VW-1:0]     div_divisor;
   logic [31:0]           abs_a, abs_b;
   logic [FRAC_BITS+1:0]  fq_sum;
   logic [32:0]           total;
   logic signed [32:0]    as_res;
   logic signed [63:0]    mul_shift;
   logic signed [31:0]    apply_val;
   logic                  apply_ovf;
   logic                  push_ok;
   logic                  mem_push, mem_apply;

   assign cnt_m1 = num_count_ff - CNT_W'(1);
   assign cnt_m2 = num_count_ff - CNT_W'(2);
   assign digit = ch_ff[3:0];
   assign int_next = (INT_W+4)'(int_ff) * (INT_W+4)'(10) + (INT_W+4)'(digit);
   assign frac_next = (FRAC_ACC_W+4)'(frac_ff) * (FRAC_ACC_W+4)'(10)
                      + (FRAC_ACC_W+4)'(digit);

   always_comb begin
      is_op = 1'b1;
      new_op = OP_ADD;
      case (ch_ff)
         CH_PLUS:  new_op = OP_ADD;
         CH_MINUS: new_op = OP_SUB;
         CH_STAR:  new_op = OP_MUL;
         CH_SLASH: new_op = OP_DIV;
         default:  is_op = 1'b0;
      endcase
   end

   assign top_op = (op_count_ff == 2'd2) ? op_stack_ff[1] : op_stack_ff[0];
   assign abs_a = a_ff[31] ? 32'(-a_ff) : 32'(a_ff);
   assign abs_b = b_ff[31] ? 32'(-b_ff) : 32'(b_ff);

   assign div_start = (cmd.code == CMD_TOK_START) || (cmd.code == CMD_DIV_START);
   assign div_dividend = (cmd.code == CMD_TOK_START)
                         ? DIV_DW'({frac_ff, {(FRAC_BITS + 1){1'b0}}})
                         : {abs_a, {FRAC_BITS{1'b0}}};
   assign div_divisor = (cmd.code == CMD_TOK_START) ? DIV_VW'(pow10(dig_ff)) : abs_b;

   iee_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .done    (div_done),
      .quotient(div_quotient)
   );

   // Rounded fraction and the unsigned token value.
   assign fq_sum = div_quotient[FRAC_BITS+1:0] + (FRAC_BITS+2)'(1);
   assign total = 33'({int_ff, {FRAC_BITS{1'b0}}}) + 33'(fq_sum[FRAC_BITS+1:1]);
   assign push_ok = num_count_ff < CNT_W'(NUM_STACK_DEPTH);

   assign as_res = (op_ff == OP_SUB) ? (33'(a_ff) - 33'(b_ff)) : (33'(a_ff) + 33'(b_ff));
   assign mul_shift = (prod_ff >>> FRAC_BITS)
                      + ((prod_ff[63] && (prod_ff[FRAC_BITS-1:0] != '0)) ? 64'sd1 : 64'sd0);

   always_comb begin
      apply_val = '0;
      apply_ovf = 1'b0;
      case (cmd.code)
         CMD_ADDSUB: begin
            if (as_res[32] != as_res[31]) begin
               apply_ovf = 1'b1;
               apply_val = as_res[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
               apply_val = as_res[31:0];
            end
         end
         CMD_MUL_FIN: begin
            if (!mul_shift[63] && (mul_shift[62:31] != '0)) begin
               apply_ovf = 1'b1;
               apply_val = 32'sh7FFF_FFFF;
            end else if (mul_shift[63] && (mul_shift[62:31] != '1)) begin
               apply_ovf = 1'b1;
               apply_val = 32'sh8000_0000;
            end else begin
               apply_val = mul_shift[31:0];
            end
         end
         CMD_DIV_FIN: begin
            if (!neg_ff) begin
               if (div_quotient[DIV_DW-1:31] != '0) begin
                  apply_ovf = 1'b1;
                  apply_val = 32'sh7FFF_FFFF;
               end else begin
                  apply_val = div_quotient[31:0];
               end
            end else if ((div_quotient[DIV_DW-1:32] != '0)
                         || (div_quotient[31] && (div_quotient[30:0] != '0))) begin
               apply_ovf = 1'b1;
               apply_val = 32'sh8000_0000;
            end else begin
               apply_val = 32'(-div_quotient[31:0]);
            end
         end
         default: apply_val = '0;
      endcase
   end

   assign mem_push = (cmd.code == CMD_TOK_PUSH) && push_ok;
   assign mem_apply = (cmd.code == CMD_ADDSUB) || (cmd.code == CMD_MUL_FIN)
                      || (cmd.code == CMD_DIV_ZERO) || (cmd.code == CMD_DIV_FIN);

   always_comb begin
      int_in = int_ff;
      frac_in = frac_ff;
      dig_in = dig_ff;
      fl_active_in = fl_active_ff;
      fl_dot_in = fl_dot_ff;
      fl_end_in = fl_end_ff;
      err_in = err_ff;
      num_count_in = num_count_ff;
      op_count_in = op_count_ff;
      unique case (cmd.code) inside
         CMD_DIGIT: begin
            fl_active_in = 1'b1;
            if (!fl_end_ff) begin
               if (fl_dot_ff) begin
                  if (dig_ff < DIG_W'(MAX_FRAC_DIGITS)) begin
                     frac_in = frac_next[FRAC_ACC_W-1:0];
                     dig_in = dig_ff + DIG_W'(1);
                  end
               end else if (int_next > (INT_W+4)'(INT_CAP)) begin
                  int_in = INT_CAP;
               end else begin
                  int_in = int_next[INT_W-1:0];
               end
            end
         end
         CMD_DOT: begin
            if (!fl_active_ff) begin
               fl_active_in = 1'b1;
               fl_dot_in = 1'b1;
            end else if (fl_dot_ff) begin
               fl_end_in = 1'b1;
            end else begin
               fl_dot_in = 1'b1;
            end
         end
         CMD_TOK_PUSH: begin
            if (err_ff == ST_OK) begin
               if (total > Q_MAX33) err_in = ST_OVERFLOW;
               else if (!push_ok) err_in = ST_MALFORMED;
            end
            if (push_ok) num_count_in = num_count_ff + CNT_W'(1);
            int_in = '0;
            frac_in = '0;
            dig_in = '0;
            fl_active_in = 1'b0;
            fl_dot_in = 1'b0;
            fl_end_in = 1'b0;
         end
         CMD_POP: begin
            op_count_in = op_count_ff - 2'd1;
            if (num_count_ff < CNT_W'(2) && err_ff == ST_OK) err_in = ST_MALFORMED;
         end
         CMD_ADDSUB, CMD_MUL_FIN, CMD_DIV_FIN: begin
            num_count_in = num_count_ff - CNT_W'(1);
            if (apply_ovf && err_ff == ST_OK) err_in = ST_OVERFLOW;
         end
         CMD_DIV_ZERO: begin
            num_count_in = num_count_ff - CNT_W'(1);
            if (err_ff == ST_OK) err_in = ST_DIV_ZERO;
         end
         CMD_PUSH_OP: begin
            if (op_count_ff >= 2'd2) begin
               if (err_ff == ST_OK) err_in = ST_MALFORMED;
            end else begin
               op_count_in = op_count_ff + 2'd1;
            end
         end
         CMD_RESULT: begin
            int_in = '0;
            frac_in = '0;
            dig_in = '0;
            fl_active_in = 1'b0;
            fl_dot_in = 1'b0;
            fl_end_in = 1'b0;
            err_in = ST_OK;
            num_count_in = '0;
            op_count_in = '0;
         end
         default: err_in = err_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_ff <= '0;
         frac_ff <= '0;
         dig_ff <= '0;
         fl_active_ff <= 1'b0;
         fl_dot_ff <= 1'b0;
         fl_end_ff <= 1'b0;
         err_ff <= ST_OK;
         num_count_ff <= '0;
         op_count_ff <= '0;
      end else begin
         int_ff <= int_in;
         frac_ff <= frac_in;
         dig_ff <= dig_in;
         fl_active_ff <= fl_active_in;
         fl_dot_ff <= fl_dot_in;
         fl_end_ff <= fl_end_in;
         err_ff <= err_in;
         num_count_ff <= num_count_in;
         op_count_ff <= op_count_in;
      end
   end

   // Payload registers, the number stack memory and the result register.
   always_ff @(posedge clock) begin
      if (cmd.code == CMD_CAPTURE) begin
         ch_ff <= req_ch;
         last_ff <= req_last;
      end
      if (cmd.code == CMD_PUSH_OP && op_count_ff < 2'd2) begin
         op_stack_ff[op_count_ff[0]] <= new_op;
      end
      if (cmd.code == CMD_POP) begin
         op_ff <= top_op;
         short_ff <= num_count_ff < CNT_W'(2);
         a_ff <= num_mem[cnt_m2[IDX_W-1:0]];
         b_ff <= num_mem[cnt_m1[IDX_W-1:0]];
      end
      if (cmd.code == CMD_MUL_PROD) begin
         prod_ff <= a_ff * b_ff;
      end
      if (cmd.code == CMD_DIV_START) begin
         neg_ff <= a_ff[31] ^ b_ff[31];
      end
      if (mem_push) begin
         num_mem[num_count_ff[IDX_W-1:0]] <= (total > Q_MAX33) ? 32'sh7FFF_FFFF
                                                                : signed'(total[31:0]);
      end else if (mem_apply) begin
         num_mem[cnt_m2[IDX_W-1:0]] <= apply_val;
      end
      if (cmd.code == CMD_RESULT) begin
         value_ff <= (num_count_ff == '0) ? 32'sd0 : num_mem[cnt_m1[IDX_W-1:0]];
         status_ff <= (err_ff == ST_OK && num_count_ff != CNT_W'(1)) ? ST_MALFORMED : err_ff;
      end
   end

   always_comb begin
      status.is_digit = (ch_ff >= CH_ZERO) && (ch_ff <= CH_NINE);
      status.is_dot = ch_ff == CH_DOT;
      status.is_op = is_op;
      status.last = last_ff;
      status.active = fl_active_ff;
      status.op_nonzero = op_count_ff != 2'd0;
      status.reduce_ok = (op_count_ff != 2'd0) && (top_op[1] >= new_op[1]);
      status.pop_short = short_ff;
      status.pop_op = op_ff;
      status.divisor_zero = b_ff == 32'sd0;
      status.div_done = div_done;
   end

   assign rsp_value = value_ff;
   assign rsp_status = status_ff;

`ifndef NO_ASSERTIONS
   a_num_count_range: assert property (@(posedge clock) disable iff (reset)
      num_count_ff <= CNT_W'(NUM_STACK_DEPTH))
      else $error("number stack count beyond depth");
   a_op_count_range: assert property (@(posedge clock) disable iff (reset)
      op_count_ff <= 2'd2)
      else $error("operator stack count beyond two");
   a_frac_digits: assert property (@(posedge clock) disable iff (reset)
      dig_ff <= DIG_W'(MAX_FRAC_DIGITS))
      else $error("too many fraction digits kept");
   a_result_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.code == CMD_RESULT |=> num_count_ff == '0 && op_count_ff == '0 && err_ff == ST_OK)
      else $error("state not cleared after result");
`endif

endmodule

// File: rtl/iee_controller.sv
// Sequencing state machine of the infix evaluator.
module iee_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output iee_pkg::iee_cmd_type    cmd,
   input  iee_pkg::iee_status_type status
);
   import iee_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_TOKEN = 4'd2;
   localparam logic [3:0] S_TOK_WAIT = 4'd3;
   localparam logic [3:0] S_AFTER_TOK = 4'd4;
   localparam logic [3:0] S_OP_LOOP = 4'd5;
   localparam logic [3:0] S_APPLY = 4'd6;
   localparam logic [3:0] S_MUL = 4'd7;
   localparam logic [3:0] S_DIV_WAIT = 4'd8;
   localparam logic [3:0] S_CHECK_LAST = 4'd9;
   localparam logic [3:0] S_FLUSH = 4'd10;
   localparam logic [3:0] S_RESULT = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       flush_ff, flush_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] back;

   assign back = flush_ff ? S_FLUSH : S_OP_LOOP;

   always_comb begin
      state_in = state_ff;
      flush_in = flush_ff;
      cmd.code = CMD_NONE;
      req_ready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.code = CMD_CAPTURE;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.is_digit) begin
               cmd.code = CMD_DIGIT;
               state_in = S_CHECK_LAST;
            end else if (status.is_dot) begin
               cmd.code = CMD_DOT;
               state_in = S_CHECK_LAST;
            end else begin
               state_in = S_TOKEN;
            end
         end
         S_TOKEN: begin
            if (status.active) begin
               cmd.code = CMD_TOK_START;
               state_in = S_TOK_WAIT;
            end else begin
               state_in = S_AFTER_TOK;
            end
         end
         S_TOK_WAIT: begin
            if (status.div_done) begin
               cmd.code = CMD_TOK_PUSH;
               state_in = S_AFTER_TOK;
            end
         end
         S_AFTER_TOK: begin
            if (flush_ff) state_in = S_FLUSH;
            else if (status.is_op) state_in = S_OP_LOOP;
            else state_in = S_CHECK_LAST;
         end
         S_OP_LOOP: begin
            if (status.reduce_ok) begin
               cmd.code = CMD_POP;
               state_in = S_APPLY;
            end else begin
               cmd.code = CMD_PUSH_OP;
               state_in = S_CHECK_LAST;
            end
         end
         S_APPLY: begin
            if (status.pop_short) begin
               state_in = back;
            end else begin
               unique case (status.pop_op) inside
                  OP_ADD, OP_SUB: begin
                     cmd.code = CMD_ADDSUB;
                     state_in = back;
                  end
                  OP_MUL: begin
                     cmd.code = CMD_MUL_PROD;
                     state_in = S_MUL;
                  end
                  default: begin
                     if (status.divisor_zero) begin
                        cmd.code = CMD_DIV_ZERO;
                        state_in = back;
                     end else begin
                        cmd.code = CMD_DIV_START;
                        state_in = S_DIV_WAIT;
                     end
                  end
               endcase
            end
         end
         S_MUL: begin
            cmd.code = CMD_MUL_FIN;
            state_in = back;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.code = CMD_DIV_FIN;
               state_in = back;
            end
         end
         S_CHECK_LAST: begin
            if (status.last) begin
               flush_in = 1'b1;
               state_in = S_TOKEN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (status.op_nonzero) begin
               cmd.code = CMD_POP;
               state_in = S_APPLY;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.code = CMD_RESULT;
               rsp_valid_in = 1'b1;
               flush_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         flush_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         flush_ff <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_flush_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !flush_ff)
      else $error("flush mode left set in idle");
   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      cmd.code == CMD_RESULT |-> !rsp_valid_ff || rsp_ready)
      else $error("result overwrote an undelivered response");
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.code == CMD_RESULT |=> rsp_valid_ff)
      else $error("response valid not raised after result");
`endif

endmodule

// File: rtl/infix_expression_evaluator.sv
// Top level of the character-serial infix expression evaluator.
// The block takes one ASCII character per request and evaluates an infix expression of
// non-negative decimal numbers and the operators + - * / with the usual precedence; the
// request marked last closes the expression and yields one response holding a signed
// Q16.16 value and a status (0 ok, 1 divide by zero, 2 overflow saturated, 3 malformed).
// An operator request first applies each pending operator of equal or higher precedence,
// a multiplication with an extra product step; each number that a request completes and
// each division that it applies go through the one shared restoring divider that
// produces a quotient bit per cycle; the last request adds the flush of up to two pending
// operators, and its response is held back only while an earlier response still waits in
// the response register.
// A new request is accepted while an earlier response still waits to be taken.
module infix_expression_evaluator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_ch,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_value,
   output logic [1:0]         rsp_status
);
   import iee_pkg::*;

   // Commands flow from the controller to the datapath, status flows back.
   iee_cmd_type    cmd;
   iee_status_type status;

   iee_controller u_controller (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (cmd),
      .status   (status)
   );

   // The datapath holds the number builder, both stacks, the divider and the
   // response register that the controller's response valid qualifies.
   iee_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_ch    (req_ch),
      .req_last  (req_last),
      .rsp_value (rsp_value),
      .rsp_status(rsp_status)
   );

endmodule
